### rtl/boi_pkg.sv
// Shared constants and codes for the breakpoint offset interpolator.
`default_nettype none

package boi_pkg;

   // Table and datapath sizes.
   localparam int DEPTH       = 64;
   localparam int TIME_BITS   = 48;
   localparam int OFFSET_BITS = 32;
   localparam int FRAC_BITS   = 16;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS    = ADDR_BITS + 1;
   localparam int SLOT_BITS   = 6;
   localparam int POINTS_BITS = 7;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 7;
   localparam int OFFS_WORD_BITS = 3 * OFFSET_BITS;

   // Item commands.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] REG_POINTS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_STRICT_RANGE  = 2'd1;

   // Where a query time fell relative to the table.
   localparam logic [1:0] WHERE_INSIDE = 2'd0;
   localparam logic [1:0] WHERE_BEFORE = 2'd1;
   localparam logic [1:0] WHERE_AFTER  = 2'd2;
   localparam logic [1:0] WHERE_EMPTY  = 2'd3;

endpackage

`default_nettype wire

### rtl/breakpoint_offset_interpolator.sv
// Top level of the breakpoint offset interpolator: table memories, scan and blend.
`default_nettype none

// A load item writes one breakpoint (time and x/y/z offset) and its result,
// all zeros, is strobed on the cycle after the item is taken; busy stays low.
// A query item scans the time memory from slot 0, one entry per cycle, for the
// first breakpoint not earlier than the query time, and keeps busy high until
// its result is strobed. A query that interpolates then takes two offset memory
// reads, a 17-step bit-serial divider for the fraction and one shared
// multiplier used once per component; one that falls outside the table or hits
// the first point skips the divider and multiplier. A query on an empty table
// answers on the next cycle. Each result is shown for exactly one cycle with
// rsp_strobe high and must be taken then. Start is ignored while busy is high.
// The user must write configuration only while busy is low and no result is
// pending; the block itself does not enforce this.
module breakpoint_offset_interpolator (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // Input items.
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic                                    req_cmd,
   input  wire logic        [boi_pkg::SLOT_BITS-1:0]    req_slot,
   input  wire logic        [boi_pkg::TIME_BITS-1:0]    req_sample_time,
   input  wire logic signed [boi_pkg::OFFSET_BITS-1:0]  req_off_x,
   input  wire logic signed [boi_pkg::OFFSET_BITS-1:0]  req_off_y,
   input  wire logic signed [boi_pkg::OFFSET_BITS-1:0]  req_off_z,
   // Result items.
   output logic                                         rsp_strobe,
   output logic signed      [boi_pkg::OFFSET_BITS-1:0]  rsp_corr_x,
   output logic signed      [boi_pkg::OFFSET_BITS-1:0]  rsp_corr_y,
   output logic signed      [boi_pkg::OFFSET_BITS-1:0]  rsp_corr_z,
   output logic             [1:0]                       rsp_where_found,
   output logic                                         rsp_range_error,
   // Configuration writes.
   input  wire logic                                    csr_we,
   input  wire logic        [boi_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic        [boi_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   import boi_pkg::*;

   localparam int PROD_BITS = OFFSET_BITS + FRAC_BITS + 3;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_RDA  = 3'd2;
   localparam logic [2:0] S_RDB  = 3'd3;
   localparam logic [2:0] S_RDC  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_MUL  = 3'd6;
   localparam logic [2:0] S_ADD  = 3'd7;

   // Control registers.
   logic [2:0]               state_ff, state_in;
   logic                     strobe_ff, strobe_in;
   logic [POINTS_BITS-1:0]   points_ff, points_in;
   logic                     strict_ff, strict_in;

   // Item working registers.
   logic [ADDR_BITS-1:0]     idx_ff, idx_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [TIME_BITS-1:0]     time_ff, time_in;
   logic [TIME_BITS-1:0]     prev_time_ff, prev_time_in;
   logic [TIME_BITS-1:0]     num_ff, num_in;
   logic [TIME_BITS-1:0]     den_ff, den_in;
   logic [1:0]               where_ff, where_in;
   logic                     interp_ff, interp_in;
   logic [OFFS_WORD_BITS-1:0] p1_ff, p1_in;
   logic [OFFS_WORD_BITS-1:0] p2_ff, p2_in;
   logic [OFFS_WORD_BITS-1:0] res_ff, res_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic [1:0]               comp_ff, comp_in;

   // Result registers.
   logic [OFFS_WORD_BITS-1:0] out_corr_ff, out_corr_in;
   logic [1:0]               out_where_ff, out_where_in;
   logic                     out_err_ff, out_err_in;

   // Memory and divider connections.
   logic                     accept;
   logic                     load_we;
   logic [ADDR_BITS-1:0]     time_raddr;
   logic [ADDR_BITS-1:0]     offs_raddr;
   logic [TIME_BITS-1:0]     time_rdata;
   logic [OFFS_WORD_BITS-1:0] offs_rdata;
   logic                     div_start;
   logic                     div_done;
   logic [FRAC_BITS:0]       div_quot;

   // Blend datapath.
   logic [OFFSET_BITS-1:0]   p1_sel, p2_sel;
   logic signed [OFFSET_BITS:0] diff;
   logic [CNT_BITS-1:0]      points_clamped;

   assign accept  = start && (state_ff == S_IDLE);
   assign load_we = accept && (req_cmd == CMD_LOAD) && (int'(req_slot) < DEPTH);
   assign points_clamped = (int'(points_ff) > DEPTH) ? CNT_BITS'(DEPTH)
                                                      : CNT_BITS'(points_ff);

   // Read addresses: the scan prefetches the next slot; the offset reads take
   // the chosen slot first and the one before it second.
   assign time_raddr = (state_ff == S_SCAN) ? idx_ff + ADDR_BITS'(1) : '0;
   assign offs_raddr = (state_ff == S_RDB) ? idx_ff - ADDR_BITS'(1) : idx_ff;

   boi_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (DEPTH)
   ) u_time_ram (
      .clock (clock),
      .we    (load_we),
      .waddr (ADDR_BITS'(req_slot)),
      .wdata (req_sample_time),
      .raddr (time_raddr),
      .rdata (time_rdata)
   );

   boi_ram #(
      .WIDTH (OFFS_WORD_BITS),
      .DEPTH (DEPTH)
   ) u_offs_ram (
      .clock (clock),
      .we    (load_we),
      .waddr (ADDR_BITS'(req_slot)),
      .wdata ({req_off_z, req_off_y, req_off_x}),
      .raddr (offs_raddr),
      .rdata (offs_rdata)
   );

   assign div_start = (state_ff == S_RDC);

   boi_frac_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // One component difference times the fraction per multiply cycle.
   always_comb begin
      p1_sel  = p1_ff[comp_ff*OFFSET_BITS +: OFFSET_BITS];
      p2_sel  = p2_ff[comp_ff*OFFSET_BITS +: OFFSET_BITS];
      diff    = $signed({p2_sel[OFFSET_BITS-1], p2_sel})
              - $signed({p1_sel[OFFSET_BITS-1], p1_sel});
      prod_in = diff * $signed({1'b0, div_quot});
   end

   // Sequencer and next-state logic.
   always_comb begin
      state_in     = state_ff;
      strobe_in    = 1'b0;
      points_in    = points_ff;
      strict_in    = strict_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      time_in      = time_ff;
      prev_time_in = prev_time_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      where_in     = where_ff;
      interp_in    = interp_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      res_in       = res_ff;
      comp_in      = comp_ff;
      out_corr_in  = out_corr_ff;
      out_where_in = out_where_ff;
      out_err_in   = out_err_ff;

      // Configuration writes; unknown indexes are dropped.
      if (csr_we) begin
         case (csr_index)
            REG_POINTS_IN_USE: points_in = POINTS_BITS'(csr_wdata);
            REG_STRICT_RANGE:  strict_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_LOAD) begin
                  strobe_in    = 1'b1;
                  out_corr_in  = '0;
                  out_where_in = WHERE_INSIDE;
                  out_err_in   = 1'b0;
               end else if (points_clamped == '0) begin
                  strobe_in    = 1'b1;
                  out_corr_in  = '0;
                  out_where_in = WHERE_EMPTY;
                  out_err_in   = strict_ff;
               end else begin
                  state_in = S_SCAN;
                  idx_in   = '0;
                  count_in = points_clamped;
                  time_in  = req_sample_time;
               end
            end
         end
         S_SCAN: begin
            // Data on the time port belongs to slot idx.
            prev_time_in = time_rdata;
            if (time_rdata >= time_ff) begin
               state_in = S_RDA;
               if (idx_ff == '0) begin
                  interp_in = 1'b0;
                  where_in  = (time_rdata == time_ff) ? WHERE_INSIDE : WHERE_BEFORE;
               end else begin
                  interp_in = 1'b1;
                  where_in  = WHERE_INSIDE;
                  num_in    = time_ff - prev_time_ff;
                  den_in    = time_rdata - prev_time_ff;
               end
            end else if ({1'b0, idx_ff} + CNT_BITS'(1) == count_ff) begin
               state_in  = S_RDA;
               interp_in = 1'b0;
               where_in  = WHERE_AFTER;
            end else begin
               idx_in = idx_ff + ADDR_BITS'(1);
            end
         end
         S_RDA: begin
            state_in = S_RDB;
         end
         S_RDB: begin
            // Offsets of the chosen slot arrive now.
            p2_in = offs_rdata;
            if (interp_ff) begin
               state_in = S_RDC;
            end else begin
               state_in     = S_IDLE;
               strobe_in    = 1'b1;
               out_where_in = where_ff;
               out_err_in   = strict_ff && (where_ff != WHERE_INSIDE);
               out_corr_in  = (strict_ff && (where_ff != WHERE_INSIDE)) ? '0 : offs_rdata;
            end
         end
         S_RDC: begin
            // Offsets of the slot before arrive; the divider starts here.
            p1_in    = offs_rdata;
            comp_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            res_in[comp_ff*OFFSET_BITS +: OFFSET_BITS] =
               p1_sel + prod_ff[FRAC_BITS +: OFFSET_BITS];
            if (comp_ff == 2'd2) begin
               state_in     = S_IDLE;
               strobe_in    = 1'b1;
               out_where_in = WHERE_INSIDE;
               out_err_in   = 1'b0;
               out_corr_in  = {p1_sel + prod_ff[FRAC_BITS +: OFFSET_BITS],
                               res_ff[OFFSET_BITS +: OFFSET_BITS],
                               res_ff[0 +: OFFSET_BITS]};
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
         points_ff <= '0;
         strict_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         points_ff <= points_in;
         strict_ff <= strict_in;
      end
   end

   // Datapath state.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      count_ff     <= count_in;
      time_ff      <= time_in;
      prev_time_ff <= prev_time_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      where_ff     <= where_in;
      interp_ff    <= interp_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      res_ff       <= res_in;
      prod_ff      <= prod_in;
      comp_ff      <= comp_in;
      out_corr_ff  <= out_corr_in;
      out_where_ff <= out_where_in;
      out_err_ff   <= out_err_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_corr_x      = out_corr_ff[0 +: OFFSET_BITS];
   assign rsp_corr_y      = out_corr_ff[OFFSET_BITS +: OFFSET_BITS];
   assign rsp_corr_z      = out_corr_ff[2*OFFSET_BITS +: OFFSET_BITS];
   assign rsp_where_found = out_where_ff;
   assign rsp_range_error = out_err_ff;

endmodule

`default_nettype wire

### rtl/boi_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module boi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read before write, read data registered in the cycle after the address.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

### rtl/boi_frac_div.sv
// Restoring divider that forms floor(num * 2^FRAC_BITS / den) one bit per cycle.
`default_nettype none

module boi_frac_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [boi_pkg::TIME_BITS-1:0]   num,
   input  wire logic [boi_pkg::TIME_BITS-1:0]   den,
   output logic                                 done,
   output logic      [boi_pkg::FRAC_BITS:0]     quot
);

   import boi_pkg::*;

   localparam int STEP_BITS = $clog2(FRAC_BITS + 1);

   logic                   active_ff, active_in;
   logic                   done_ff, done_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [TIME_BITS-1:0]   rem_ff, rem_in;
   logic [TIME_BITS-1:0]   den_ff, den_in;
   logic [FRAC_BITS:0]     quot_ff, quot_in;
   logic [TIME_BITS:0]     shifted;
   logic [TIME_BITS:0]     diff;
   logic                   ge;

   // One restoring step: the first step has no shift and gives the integer bit.
   always_comb begin
      shifted = (step_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      diff    = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});
   end

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      quot_in   = quot_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         rem_in    = num;
         den_in    = den;
         quot_in   = '0;
      end else if (active_ff) begin
         rem_in  = ge ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
         quot_in = {quot_ff[FRAC_BITS-1:0], ge};
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(FRAC_BITS)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   // Datapath state.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

### rtl/boi_checker.sv
// Port-level checks for the breakpoint offset interpolator, bound to the top level.
`default_nettype none

module boi_checker (
   input wire logic                                    clock,
   input wire logic                                    reset,
   input wire logic                                    start,
   input wire logic                                    busy,
   input wire logic                                    req_cmd,
   input wire logic                                    rsp_strobe,
   input wire logic signed [boi_pkg::OFFSET_BITS-1:0]  rsp_corr_x,
   input wire logic signed [boi_pkg::OFFSET_BITS-1:0]  rsp_corr_y,
   input wire logic signed [boi_pkg::OFFSET_BITS-1:0]  rsp_corr_z,
   input wire logic        [1:0]                       rsp_where_found,
   input wire logic                                    rsp_range_error
);

   import boi_pkg::*;

   // A load answers on the next cycle with an inside, error-free item.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_LOAD) |=>
         rsp_strobe && (rsp_where_found == WHERE_INSIDE) && !rsp_range_error)
      else $error("load item did not answer on the next cycle");

   // A query either keeps the block busy or answers at once.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_QUERY) |=> busy || rsp_strobe)
      else $error("query item was dropped");

   // An error is only reported for a query that does not fall inside the table.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_range_error |-> rsp_where_found != WHERE_INSIDE)
      else $error("range error on an inside item");

   // Errors and empty tables give zero offsets.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_range_error || (rsp_where_found == WHERE_EMPTY)) |->
         (rsp_corr_x == '0) && (rsp_corr_y == '0) && (rsp_corr_z == '0))
      else $error("nonzero offsets with error or empty table");

   // No result appears while a query is still being worked on.
   assert property (@(posedge clock) disable iff (reset)
      busy && $past(busy) |-> !rsp_strobe)
      else $error("result strobed in the middle of a query");

endmodule

bind breakpoint_offset_interpolator boi_checker u_boi_checker (.*);

`default_nettype wire
